// ===== design/cau_pkg.sv =====
// shared constants, codes and pipeline types of the complex arithmetic unit
package cau_pkg;

  // operand format
  localparam int DW = 16;
  localparam int FB = 12;

  // derived datapath widths
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int QW  = DW + 1;
  localparam int DVW = PW;
  localparam int RW  = DVW + QW;

  // edges from an accepted item to the sampled result strobe
  localparam int LAT = QW + 4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  // one item in the divide section of the pipeline
  typedef struct packed {
    logic                 vld;
    op_t                  op;
    logic signed [SW-1:0] val_re;
    logic signed [SW-1:0] val_im;
    logic                 neg_re;
    logic                 neg_im;
    logic [RW-1:0]        rem_re;
    logic [RW-1:0]        rem_im;
    logic [QW-1:0]        q_re;
    logic [QW-1:0]        q_im;
    logic [DVW-1:0]       d;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 dz;
  } div_t;

endpackage

// ===== design/complex_arith_unit_top.sv =====
// top level of the pipelined complex arithmetic unit
// Complex add, subtract, multiply and divide on Q4.12 operands.
// Input channel: an item (opcode and both operands) is taken at a rising edge
// with start high and busy low. busy stays low: the datapath is fully
// pipelined, so an item can be taken on every cycle.
// Output channel: each result (r_real, r_imag, status) is shown for exactly one
// cycle with done high, in the order the items came in.
// Pipeline: input, product and combine stages, then the restoring divider,
// one quotient bit per stage over 17 stages, then the saturate stage.
// Throughput: one item per cycle, for every opcode.
// Reset: rst, synchronous, clears all stage valid bits; items in flight are
// dropped and no done follows until a new item is taken.
// The receiver cannot stall: results are pushed out as they complete.
module complex_arith_unit_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic signed [cau_pkg::DW-1:0] a_real,
  input  logic signed [cau_pkg::DW-1:0] a_imag,
  input  logic signed [cau_pkg::DW-1:0] b_real,
  input  logic signed [cau_pkg::DW-1:0] b_imag,
  output logic                      done,
  output logic signed [cau_pkg::DW-1:0] r_real,
  output logic signed [cau_pkg::DW-1:0] r_imag,
  output logic [1:0]                status
);

  localparam logic signed [cau_pkg::SW-1:0] HI =
    cau_pkg::SW'((64'd1 << (cau_pkg::DW - 1)) - 64'd1);
  localparam logic signed [cau_pkg::SW-1:0] LO = -HI - cau_pkg::SW'(1);
  localparam logic [cau_pkg::QW-1:0] QHI = cau_pkg::QW'(HI);
  localparam logic [cau_pkg::QW-1:0] QLO = QHI + cau_pkg::QW'(1);

  // one restoring step on both lanes
  function automatic cau_pkg::div_t div_step(input cau_pkg::div_t s, input logic [4:0] sh);
    cau_pkg::div_t r;
    logic [cau_pkg::RW-1:0] cmp;
    r = s;
    cmp = cau_pkg::RW'(s.d) << sh;
    if (s.rem_re >= cmp) begin
      r.rem_re = s.rem_re - cmp;
      r.q_re[sh] = 1'b1;
    end
    if (s.rem_im >= cmp) begin
      r.rem_im = s.rem_im - cmp;
      r.q_im[sh] = 1'b1;
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // stage 1: input register
  logic vld1;
  cau_pkg::op_t op1;
  logic signed [cau_pkg::DW-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start && !busy;
    end
    op1 <= cau_pkg::op_t'(opcode);
    ar1 <= a_real;
    ai1 <= a_imag;
    br1 <= b_real;
    bi1 <= b_imag;
  end

  // stage 2: products and plain sums
  logic vld2;
  cau_pkg::op_t op2;
  logic signed [cau_pkg::PW-1:0] arbr, aibi, aibr, arbi, brbr, bibi;
  logic signed [cau_pkg::DW:0] as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    op2  <= op1;
    arbr <= ar1 * br1;
    aibi <= ai1 * bi1;
    aibr <= ai1 * br1;
    arbi <= ar1 * bi1;
    brbr <= br1 * br1;
    bibi <= bi1 * bi1;
    if (op1 == cau_pkg::OP_SUB) begin
      as_re <= (cau_pkg::DW+1)'(ar1) - (cau_pkg::DW+1)'(br1);
      as_im <= (cau_pkg::DW+1)'(ai1) - (cau_pkg::DW+1)'(bi1);
    end else begin
      as_re <= (cau_pkg::DW+1)'(ar1) + (cau_pkg::DW+1)'(br1);
      as_im <= (cau_pkg::DW+1)'(ai1) + (cau_pkg::DW+1)'(bi1);
    end
  end

  // stage 3: combine products, truncate multiply, form divide numerators
  logic signed [cau_pkg::SW-1:0] m_re, m_im, n_re, n_im, t_re, t_im;
  logic [cau_pkg::SW-1:0] mag_re, mag_im;
  cau_pkg::div_t s3;

  always_comb begin
    m_re = cau_pkg::SW'(arbr) - cau_pkg::SW'(aibi);
    m_im = cau_pkg::SW'(aibr) + cau_pkg::SW'(arbi);
    n_re = cau_pkg::SW'(arbr) + cau_pkg::SW'(aibi);
    n_im = cau_pkg::SW'(aibr) - cau_pkg::SW'(arbi);
    // bias negatives so the shift truncates toward zero
    t_re = m_re + (m_re[cau_pkg::SW-1] ?
      cau_pkg::SW'((64'd1 << cau_pkg::FB) - 64'd1) : cau_pkg::SW'(0));
    t_im = m_im + (m_im[cau_pkg::SW-1] ?
      cau_pkg::SW'((64'd1 << cau_pkg::FB) - 64'd1) : cau_pkg::SW'(0));
    mag_re = n_re[cau_pkg::SW-1] ? -n_re : n_re;
    mag_im = n_im[cau_pkg::SW-1] ? -n_im : n_im;
    s3 = '0;
    s3.vld = vld2;
    s3.op  = op2;
    case (op2)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        s3.val_re = cau_pkg::SW'(as_re);
        s3.val_im = cau_pkg::SW'(as_im);
      end
      cau_pkg::OP_MUL: begin
        s3.val_re = t_re >>> cau_pkg::FB;
        s3.val_im = t_im >>> cau_pkg::FB;
      end
      default: begin
        s3.val_re = '0;
        s3.val_im = '0;
      end
    endcase
    s3.neg_re = n_re[cau_pkg::SW-1];
    s3.neg_im = n_im[cau_pkg::SW-1];
    s3.rem_re = cau_pkg::RW'(mag_re) << cau_pkg::FB;
    s3.rem_im = cau_pkg::RW'(mag_im) << cau_pkg::FB;
    s3.d  = cau_pkg::DVW'(brbr) + cau_pkg::DVW'(bibi);
    s3.dz = (cau_pkg::DVW'(brbr) + cau_pkg::DVW'(bibi)) == '0;
    // quotient too wide for the divider lanes
    s3.ovf_re = s3.rem_re >= {s3.d, {cau_pkg::QW{1'b0}}};
    s3.ovf_im = s3.rem_im >= {s3.d, {cau_pkg::QW{1'b0}}};
  end

  // stage 4 register and divider stages
  cau_pkg::div_t dv [0:cau_pkg::QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= cau_pkg::QW; i++) begin
        dv[i] <= '0;
      end
    end else begin
      dv[0] <= s3;
      for (int i = 0; i < cau_pkg::QW; i++) begin
        dv[i+1] <= div_step(dv[i], 5'(cau_pkg::QW - 1 - i));
      end
    end
  end

  // final stage: pick the result, saturate and report status
  cau_pkg::div_t fin;
  logic sat_re, sat_im;
  logic signed [cau_pkg::DW-1:0] o_re, o_im;
  cau_pkg::status_t st;

  always_comb begin
    fin = dv[cau_pkg::QW];
    sat_re = 1'b0;
    sat_im = 1'b0;
    o_re = '0;
    o_im = '0;
    st = cau_pkg::ST_OK;
    if (fin.op == cau_pkg::OP_DIV) begin
      if (fin.dz) begin
        st = cau_pkg::ST_DIV0;
      end else begin
        sat_re = fin.ovf_re || (fin.neg_re ? fin.q_re > QLO : fin.q_re > QHI);
        sat_im = fin.ovf_im || (fin.neg_im ? fin.q_im > QLO : fin.q_im > QHI);
        if (sat_re) begin
          o_re = fin.neg_re ? cau_pkg::DW'(LO) : cau_pkg::DW'(HI);
        end else begin
          o_re = fin.neg_re ? -cau_pkg::DW'(fin.q_re) : cau_pkg::DW'(fin.q_re);
        end
        if (sat_im) begin
          o_im = fin.neg_im ? cau_pkg::DW'(LO) : cau_pkg::DW'(HI);
        end else begin
          o_im = fin.neg_im ? -cau_pkg::DW'(fin.q_im) : cau_pkg::DW'(fin.q_im);
        end
      end
    end else begin
      sat_re = (fin.val_re > HI) || (fin.val_re < LO);
      sat_im = (fin.val_im > HI) || (fin.val_im < LO);
      o_re = (fin.val_re > HI) ? cau_pkg::DW'(HI) :
             (fin.val_re < LO) ? cau_pkg::DW'(LO) : cau_pkg::DW'(fin.val_re);
      o_im = (fin.val_im > HI) ? cau_pkg::DW'(HI) :
             (fin.val_im < LO) ? cau_pkg::DW'(LO) : cau_pkg::DW'(fin.val_im);
    end
    if (sat_re || sat_im) begin
      st = cau_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.vld;
    end
    r_real <= o_re;
    r_imag <= o_im;
    status <= st;
  end

endmodule

// ===== design/cau_checker.sv =====
// port-level checker for the complex arithmetic unit, bound to the top level
module cau_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [cau_pkg::DW-1:0] r_real,
  input logic signed [cau_pkg::DW-1:0] r_imag,
  input logic [1:0]                status
);

  // every result traces back to an item taken a fixed latency earlier
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, cau_pkg::LAT))
    else $error("result without a matching item");

  // the pipeline never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  // divide by zero gives zero parts
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == cau_pkg::ST_DIV0) |-> (r_real == '0 && r_imag == '0))
    else $error("divide by zero with nonzero parts");

  // saturation status means one part sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (done && status == cau_pkg::ST_SAT) |->
      (r_real == {1'b0, {(cau_pkg::DW-1){1'b1}}} ||
       r_real == {1'b1, {(cau_pkg::DW-1){1'b0}}} ||
       r_imag == {1'b0, {(cau_pkg::DW-1){1'b1}}} ||
       r_imag == {1'b1, {(cau_pkg::DW-1){1'b0}}}))
    else $error("saturation status without a clamped part");

  // reserved status code never shows
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != cau_pkg::ST_RSVD)
    else $error("reserved status code");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .r_real (r_real),
  .r_imag (r_imag),
  .status (status)
);
